[design/fdmd_pkg.sv]
// fdmd_pkg: types and constants shared by the frame difference motion detector
// field widths, phase codes, register indexes, reset values, back-end states
// no dependencies
package fdmd_pkg;

  localparam int PIX_W      = 8;
  localparam int SUM_W      = 30;
  localparam int TOTAL_W    = 36;
  localparam int RATIO_W    = 10;
  localparam int COUNT_W    = 8;
  localparam int STARTUP_W  = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [TOTAL_W-1:0] TOTAL_CAP = '1;
  localparam logic [COUNT_W-1:0] QUIET_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_DISCARD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = 2'd2;

  localparam logic [COUNT_W-1:0] DISCARD_RESET = 8'd10;
  localparam logic [RATIO_W-1:0] RATIO_RESET   = 10'd110;
  localparam logic [COUNT_W-1:0] HOLD_RESET    = 8'd2;

  typedef enum logic [1:0] {
    PH_DISCARD = 2'd0,
    PH_STABLE  = 2'd1,
    PH_DETECT  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CALC,
    BK_DECIDE
  } back_state_t;

  typedef struct packed {
    logic [COUNT_W-1:0] discard_frames;
    logic [RATIO_W-1:0] ratio_percent;
    logic [COUNT_W-1:0] hold_frames;
  } cfg_regs_t;

endpackage

[design/fdmd_ifs.sv]
// fdmd channel interfaces: pixel pair input, frame result output, register writes
// depends on fdmd_pkg for field widths
interface fdmd_pix_if;
  logic                       valid;
  logic                       ready;
  logic [fdmd_pkg::PIX_W-1:0] pixel_first;
  logic [fdmd_pkg::PIX_W-1:0] pixel_second;
  logic                       frame_end;

  modport source (output valid, pixel_first, pixel_second, frame_end, input ready);
  modport sink   (input valid, pixel_first, pixel_second, frame_end, output ready);
endinterface

interface fdmd_res_if;
  logic                         valid;
  logic                         ready;
  logic [fdmd_pkg::SUM_W-1:0]   frame_sum;
  logic                         motion;
  logic                         recording;
  logic                         recording_ended;
  logic [1:0]                   phase;
  logic [fdmd_pkg::TOTAL_W-1:0] window_total;

  modport source (output valid, frame_sum, motion, recording, recording_ended, phase,
                  window_total, input ready);
  modport sink   (input valid, frame_sum, motion, recording, recording_ended, phase,
                  window_total, output ready);
endinterface

interface fdmd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fdmd_pkg::CFG_IDX_W-1:0]  index;
  logic [fdmd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/fdmd_front.sv]
// fdmd_front: takes pixel pairs and accumulates saturating absolute differences
// pushes the frame sum into the frame queue on the last pair of a frame
// depends on fdmd_pkg and fdmd_pix_if
module fdmd_front #(
  parameter int MAX_FRAME_PIXELS = 4194304
) (
  input  logic                       clk,
  input  logic                       rst,
  fdmd_pix_if.sink                   pix,
  output logic                       push_valid,
  output logic [fdmd_pkg::SUM_W-1:0] push_sum,
  input  logic                       push_ready
);
  import fdmd_pkg::*;

  localparam logic [SUM_W-1:0] SUM_CAP = SUM_W'(longint'(255) * longint'(MAX_FRAME_PIXELS));

  logic [SUM_W-1:0] acc;
  logic [PIX_W-1:0] diff;
  logic [SUM_W:0]   acc_wide;
  logic [SUM_W-1:0] acc_sat;
  logic             accept;

  assign pix.ready = push_ready;
  assign accept    = pix.valid & pix.ready;

  assign diff     = (pix.pixel_first > pix.pixel_second) ? pix.pixel_first - pix.pixel_second
                                                         : pix.pixel_second - pix.pixel_first;
  assign acc_wide = {1'b0, acc} + (SUM_W+1)'(diff);
  assign acc_sat  = (acc_wide > {1'b0, SUM_CAP}) ? SUM_CAP : acc_wide[SUM_W-1:0];

  assign push_valid = accept & pix.frame_end;
  assign push_sum   = acc_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (accept) begin
      acc <= pix.frame_end ? '0 : acc_sat;
    end
  end

endmodule

[design/fdmd_queue.sv]
// fdmd_queue: short fifo of frame sums between the front and back ends
// depends on fdmd_pkg
module fdmd_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push_valid,
  input  logic [fdmd_pkg::SUM_W-1:0] push_sum,
  output logic                       push_ready,
  output logic                       pop_valid,
  output logic [fdmd_pkg::SUM_W-1:0] pop_sum,
  input  logic                       pop_ready
);
  import fdmd_pkg::*;

  logic [SUM_W-1:0]  entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_sum    = entries[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[design/fdmd_back.sv]
// fdmd_back: per-frame decision; phase, threshold test, window ring and sum,
// recording flag with hold count, registered result output
// depends on fdmd_pkg and fdmd_res_if
module fdmd_back #(
  parameter int WINDOW_FRAMES = 50
) (
  input  logic                       clk,
  input  logic                       rst,
  input  fdmd_pkg::cfg_regs_t        cfg_regs,
  input  logic                       pop_valid,
  input  logic [fdmd_pkg::SUM_W-1:0] pop_sum,
  output logic                       pop_ready,
  fdmd_res_if.source                 res
);
  import fdmd_pkg::*;

  localparam int PTR_W       = (WINDOW_FRAMES > 1) ? $clog2(WINDOW_FRAMES) : 1;
  localparam int LHS_SCALE   = 100 * WINDOW_FRAMES;
  localparam int LHS_SCALE_W = $clog2(LHS_SCALE + 1);
  localparam int LHS_W       = SUM_W + LHS_SCALE_W;
  localparam int RHS_W       = TOTAL_W + RATIO_W;
  localparam int CMP_W       = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam logic [PTR_W-1:0]     PTR_LAST  = PTR_W'(WINDOW_FRAMES - 1);
  localparam logic [STARTUP_W:0]   WIN_COUNT = (STARTUP_W+1)'(WINDOW_FRAMES);
  localparam logic [LHS_SCALE_W-1:0] SCALE   = LHS_SCALE_W'(LHS_SCALE);

  back_state_t state, state_next;

  logic [SUM_W-1:0]     ring [WINDOW_FRAMES];
  logic [SUM_W-1:0]     rd_data;
  logic [PTR_W-1:0]     ptr, ptr_next;
  logic [SUM_W-1:0]     fsum;
  logic [LHS_W-1:0]     lhs;
  logic [RHS_W-1:0]     rhs;
  logic [TOTAL_W-1:0]   drained;
  logic [TOTAL_W-1:0]   window_sum, window_sum_next;
  logic [STARTUP_W-1:0] startup_count, startup_next;
  logic [COUNT_W-1:0]   quiet_count, quiet_next;
  logic                 record_flag, record_next;

  logic                 res_valid;
  logic [SUM_W-1:0]     out_sum;
  logic                 out_motion;
  logic                 out_recording;
  logic                 out_ended;
  phase_t               out_phase;
  logic [TOTAL_W-1:0]   out_total;

  logic                 load;
  logic                 ring_we;
  logic                 motion_now;
  logic                 ended_now;
  phase_t               phase_now;
  logic [STARTUP_W:0]   cnt_ext;
  logic [STARTUP_W:0]   disc_ext;
  logic                 exceed;
  logic [TOTAL_W-1:0]   sum_base;
  logic [TOTAL_W:0]     sum_wide;
  logic [TOTAL_W-1:0]   sum_sat;

  // control fsm
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop_ready  = 1'b0;
    load       = 1'b0;
    case (state)
      BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) state_next = BK_CALC;
      end
      BK_CALC: begin
        state_next = BK_DECIDE;
      end
      BK_DECIDE: begin
        if (!res_valid || res.ready) begin
          load       = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // phase and threshold decision
  assign cnt_ext  = {1'b0, startup_count};
  assign disc_ext = (STARTUP_W+1)'(cfg_regs.discard_frames);
  assign exceed   = CMP_W'(lhs) > CMP_W'(rhs);

  always_comb begin
    if (cnt_ext < disc_ext) begin
      phase_now = PH_DISCARD;
    end else if (cnt_ext < disc_ext + WIN_COUNT) begin
      phase_now = PH_STABLE;
    end else begin
      phase_now = PH_DETECT;
    end
  end

  assign sum_base = (phase_now == PH_STABLE) ? window_sum : drained;
  assign sum_wide = {1'b0, sum_base} + (TOTAL_W+1)'(fsum);
  assign sum_sat  = sum_wide[TOTAL_W] ? TOTAL_CAP : sum_wide[TOTAL_W-1:0];

  always_comb begin
    window_sum_next = window_sum;
    startup_next    = startup_count;
    quiet_next      = quiet_count;
    record_next     = record_flag;
    ptr_next        = ptr;
    ring_we         = 1'b0;
    motion_now      = 1'b0;
    ended_now       = 1'b0;
    case (phase_now)
      PH_DISCARD: begin
        startup_next = startup_count + 1'b1;
      end
      PH_STABLE: begin
        ring_we         = load;
        window_sum_next = sum_sat;
        ptr_next        = (ptr == PTR_LAST) ? '0 : ptr + 1'b1;
        startup_next    = startup_count + 1'b1;
      end
      PH_DETECT: begin
        if (exceed) begin
          motion_now  = 1'b1;
          record_next = 1'b1;
          quiet_next  = COUNT_W'(1);
        end else begin
          if (quiet_count >= cfg_regs.hold_frames) begin
            ended_now       = record_flag;
            record_next     = 1'b0;
            ring_we         = load;
            window_sum_next = sum_sat;
            ptr_next        = (ptr == PTR_LAST) ? '0 : ptr + 1'b1;
          end
          if (quiet_count < QUIET_MAX) quiet_next = quiet_count + 1'b1;
        end
      end
      default: begin
        startup_next = startup_count;
      end
    endcase
  end

  // window ring memory
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ptr] <= fsum;
    end
    rd_data <= ring[ptr];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == BK_IDLE && pop_valid) begin
      fsum <= pop_sum;
    end
    if (state == BK_CALC) begin
      lhs     <= LHS_W'(fsum) * LHS_W'(SCALE);
      rhs     <= RHS_W'(cfg_regs.ratio_percent) * RHS_W'(window_sum);
      drained <= (window_sum < TOTAL_W'(rd_data)) ? '0 : window_sum - TOTAL_W'(rd_data);
    end
    if (load) begin
      out_sum       <= fsum;
      out_motion    <= motion_now;
      out_recording <= record_next;
      out_ended     <= ended_now;
      out_phase     <= phase_now;
      out_total     <= window_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum    <= '0;
      startup_count <= '0;
      quiet_count   <= '0;
      record_flag   <= 1'b0;
      ptr           <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (load) begin
        window_sum    <= window_sum_next;
        startup_count <= startup_next;
        quiet_count   <= quiet_next;
        record_flag   <= record_next;
        ptr           <= ptr_next;
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign res.valid           = res_valid;
  assign res.frame_sum       = out_sum;
  assign res.motion          = out_motion;
  assign res.recording       = out_recording;
  assign res.recording_ended = out_ended;
  assign res.phase           = out_phase;
  assign res.window_total    = out_total;

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    int'(ptr) < WINDOW_FRAMES)
    else $error("ring pointer out of range");

  a_load_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == BK_DECIDE))
    else $error("result loaded outside decide state");

  a_motion_records: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_motion |-> out_recording && !out_ended && out_phase == PH_DETECT)
    else $error("motion result without recording");

  a_ended_clears: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_ended |-> !out_recording && out_total == window_sum)
    else $error("recording ended but flag still set");

  a_total_stable_idle: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(window_sum))
    else $error("window sum changed without a frame decision");

endmodule

[design/frame_diff_motion_detector_core.sv]
// frame_diff_motion_detector_core: top level of the frame difference motion detector
// register bank, front accumulator, frame queue, back-end decision unit
// depends on fdmd_pkg, fdmd_ifs, fdmd_front, fdmd_queue, fdmd_back
//
//   channel  dir  transfer moves
//   pix      in   one pixel pair (pixel_first, pixel_second, frame_end)
//   res      out  one frame result, only after a pair with frame_end set
//   cfg      in   register write (index, data), always ready
//
// one pixel pair per cycle while the frame queue has room; the accumulator add and saturate is the only work per pair
// each frame end takes the back end through pop, multiply and ring read, then decide
// a four entry queue of frame sums lets the front keep taking pairs meanwhile
// pix stalls only when the queue is full; res stalls hold the back end in decide
// synchronous reset; the window ring has no clearing pass, entries are written before use
module frame_diff_motion_detector_core #(
  parameter int WINDOW_FRAMES    = 50,
  parameter int MAX_FRAME_PIXELS = 4194304
) (
  input  logic        clk,
  input  logic        rst,
  fdmd_pix_if.sink    pix,
  fdmd_res_if.source  res,
  fdmd_cfg_if.sink    cfg
);
  import fdmd_pkg::*;

  cfg_regs_t        cfg_regs;
  logic             push_valid;
  logic [SUM_W-1:0] push_sum;
  logic             push_ready;
  logic             pop_valid;
  logic [SUM_W-1:0] pop_sum;
  logic             pop_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.discard_frames <= DISCARD_RESET;
      cfg_regs.ratio_percent  <= RATIO_RESET;
      cfg_regs.hold_frames    <= HOLD_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_DISCARD: cfg_regs.discard_frames <= cfg.data[COUNT_W-1:0];
        CFG_RATIO:   cfg_regs.ratio_percent  <= cfg.data[RATIO_W-1:0];
        CFG_HOLD:    cfg_regs.hold_frames    <= cfg.data[COUNT_W-1:0];
        default:     cfg_regs                <= cfg_regs;
      endcase
    end
  end

  fdmd_front #(
    .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .pix        (pix),
    .push_valid (push_valid),
    .push_sum   (push_sum),
    .push_ready (push_ready)
  );

  fdmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_sum   (push_sum),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_sum    (pop_sum),
    .pop_ready  (pop_ready)
  );

  fdmd_back #(
    .WINDOW_FRAMES (WINDOW_FRAMES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_regs  (cfg_regs),
    .pop_valid (pop_valid),
    .pop_sum   (pop_sum),
    .pop_ready (pop_ready),
    .res       (res)
  );

endmodule

[verif/frame_diff_motion_detector_core_tb.sv]
`timescale 1ns / 100ps
// frame_diff_motion_detector_core_tb: self-checking bench for the frame difference motion detector
// predicts each frame result from the pixel pair stream and compares field by field
// depends on fdmd_pkg, fdmd_ifs and frame_diff_motion_detector_core
module frame_diff_motion_detector_core_tb;
  import fdmd_pkg::*;

  localparam int WINDOW_FRAMES    = 50;
  localparam int MAX_FRAME_PIXELS = 4194304;
  localparam logic [SUM_W-1:0] SUM_CAP = SUM_W'(255 * MAX_FRAME_PIXELS);
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [PIX_W-1:0] first_px;
    logic [PIX_W-1:0] second_px;
    logic             frame_end;
  } pixel_pair_t;

  typedef struct packed {
    logic [SUM_W-1:0]   frame_sum;
    logic               motion;
    logic               recording;
    logic               recording_ended;
    phase_t             phase;
    logic [TOTAL_W-1:0] window_total;
  } frame_result_t;

  logic clk;
  logic rst;

  fdmd_pix_if pix();
  fdmd_res_if res();
  fdmd_cfg_if cfg();

  frame_diff_motion_detector_core #(
    .WINDOW_FRAMES(WINDOW_FRAMES),
    .MAX_FRAME_PIXELS(MAX_FRAME_PIXELS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .pix(pix),
    .res(res),
    .cfg(cfg)
  );

  pixel_pair_t   pair_queue[$];
  frame_result_t pending_frame_results[$];
  pixel_pair_t   drive_pair;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            error_count;

  // detector state as predicted from the accepted transfers
  logic [COUNT_W-1:0] discard_cfg    = DISCARD_RESET;
  logic [RATIO_W-1:0] ratio_cfg      = RATIO_RESET;
  logic [COUNT_W-1:0] hold_cfg       = HOLD_RESET;
  logic [SUM_W-1:0]   diff_acc       = '0;
  logic [SUM_W-1:0]   sum_ring[WINDOW_FRAMES];
  logic [TOTAL_W-1:0] win_total      = '0;
  logic [5:0]         ring_ptr       = '0;
  int                 startup_frames = 0;
  logic [COUNT_W-1:0] quiet_frames   = '0;
  logic               record_on      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  task automatic add_to_window(input logic [SUM_W-1:0] fsum);
    logic [TOTAL_W:0] total_next;
    total_next = {1'b0, win_total} + fsum;
    win_total = (total_next > TOTAL_CAP) ? TOTAL_CAP : total_next[TOTAL_W-1:0];
    sum_ring[ring_ptr] = fsum;
    ring_ptr = (ring_ptr == WINDOW_FRAMES - 1) ? '0 : ring_ptr + 1'b1;
  endtask

  task automatic accumulate_pair(input logic [PIX_W-1:0] first_px,
                                 input logic [PIX_W-1:0] second_px, input logic frame_end);
    logic [PIX_W-1:0]   diff;
    logic [SUM_W:0]     acc_next;
    logic [SUM_W-1:0]   fsum;
    longint unsigned    lhs;
    longint unsigned    rhs;
    frame_result_t      r;
    diff = (first_px > second_px) ? first_px - second_px : second_px - first_px;
    acc_next = {1'b0, diff_acc} + diff;
    diff_acc = (acc_next > SUM_CAP) ? SUM_CAP : acc_next[SUM_W-1:0];
    if (!frame_end) return;
    fsum = diff_acc;
    diff_acc = '0;
    r = '0;
    r.frame_sum = fsum;
    if (startup_frames < discard_cfg) begin
      r.phase = PH_DISCARD;
      startup_frames++;
    end else if (startup_frames < discard_cfg + WINDOW_FRAMES) begin
      r.phase = PH_STABLE;
      add_to_window(fsum);
      startup_frames++;
    end else begin
      r.phase = PH_DETECT;
      lhs = longint'(fsum) * 100 * WINDOW_FRAMES;
      rhs = longint'(ratio_cfg) * longint'(win_total);
      if (lhs > rhs) begin
        r.motion = 1'b1;
        record_on = 1'b1;
        quiet_frames = 8'd1;
      end else begin
        if (quiet_frames >= hold_cfg) begin
          // quiet past the hold: oldest window entry gives way to this frame
          r.recording_ended = record_on;
          record_on = 1'b0;
          win_total = (sum_ring[ring_ptr] > win_total) ? '0 : win_total - sum_ring[ring_ptr];
          add_to_window(fsum);
        end
        if (quiet_frames < QUIET_MAX) quiet_frames++;
      end
    end
    r.recording = record_on;
    r.window_total = win_total;
    pending_frame_results.insert(pending_frame_results.size(), r);
  endtask

  task automatic check_result();
    frame_result_t want;
    if (pending_frame_results.size() == 0) begin
      report_mismatch("result with none pending, frame_sum", res.frame_sum, 0);
      return;
    end
    want = pending_frame_results.pop_front();
    if (res.frame_sum !== want.frame_sum)
      report_mismatch("frame_sum", res.frame_sum, want.frame_sum);
    if (res.motion !== want.motion)
      report_mismatch("motion", res.motion, want.motion);
    if (res.recording !== want.recording)
      report_mismatch("recording", res.recording, want.recording);
    if (res.recording_ended !== want.recording_ended)
      report_mismatch("recording_ended", res.recording_ended, want.recording_ended);
    if (res.phase !== want.phase)
      report_mismatch("phase", res.phase, want.phase);
    if (res.window_total !== want.window_total)
      report_mismatch("window_total", res.window_total, want.window_total);
  endtask

  // pixel pair driver
  always @(posedge clk) begin
    if (rst) begin
      pix.valid        <= 1'b0;
      pix.pixel_first  <= '0;
      pix.pixel_second <= '0;
      pix.frame_end    <= 1'b0;
    end else if (!pix.valid || pix.ready) begin
      if (pair_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_pair = pair_queue.pop_front();
        pix.valid        <= 1'b1;
        pix.pixel_first  <= drive_pair.first_px;
        pix.pixel_second <= drive_pair.second_px;
        pix.frame_end    <= drive_pair.frame_end;
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    res.ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: register writes, results, accepted pairs
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_DISCARD: discard_cfg = cfg.data[COUNT_W-1:0];
          CFG_RATIO:   ratio_cfg   = cfg.data;
          CFG_HOLD:    hold_cfg    = cfg.data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (res.valid && res.ready) check_result();
      if (pix.valid && pix.ready) accumulate_pair(pix.pixel_first, pix.pixel_second, pix.frame_end);
    end
  end

  task automatic push_pair(input logic [PIX_W-1:0] first_px, input logic [PIX_W-1:0] second_px,
                           input logic frame_end);
    pixel_pair_t p;
    p = '{first_px, second_px, frame_end};
    pair_queue.insert(pair_queue.size(), p);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  task automatic settle();
    do @(posedge clk);
    while (pair_queue.size() != 0 || pix.valid || pending_frame_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random frames: still scenes, small noise, or full change
  task automatic run_frames(input int frames, input int send_pct, input int stall_pct);
    int               len;
    int               style;
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    repeat (frames) begin
      len = ($urandom_range(15) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      style = $urandom_range(3);
      for (int i = 0; i < len; i++) begin
        a = $urandom_range(255);
        case (style)
          0: b = a;
          1: b = a ^ $urandom_range(3);
          default: b = $urandom_range(255);
        endcase
        push_pair(a, b, i == len - 1);
      end
    end
    settle();
  endtask

  initial begin
    logic [PIX_W-1:0] level;
    rst = 1'b1;
    cfg.valid = 1'b0;
    cfg.index = CFG_DISCARD;
    cfg.data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    error_count = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // pixel extremes while discarding under reset settings
    push_pair(8'd0, 8'd255, 1'b1);
    push_pair(8'd255, 8'd0, 1'b0);
    push_pair(8'd255, 8'd255, 1'b0);
    push_pair(8'd0, 8'd0, 1'b1);
    push_pair(8'hAA, 8'h55, 1'b0);
    push_pair(8'h55, 8'hAA, 1'b1);
    push_pair(8'd1, 8'd0, 1'b1);
    push_pair(8'd0, 8'd1, 1'b0);
    push_pair(8'd128, 8'd127, 1'b0);
    push_pair(8'd127, 8'd128, 1'b1);
    push_pair(8'd200, 8'd200, 1'b1);
    run_frames(70, 0, 0);

    // zero ratio, zero hold
    write_reg(CFG_RATIO, 10'd0);
    write_reg(CFG_HOLD, 10'd0);
    run_frames(20, 47, 0);

    // largest ratio and hold: one busy frame then a long still stretch
    write_reg(CFG_RATIO, 10'd1023);
    write_reg(CFG_HOLD, 10'd255);
    for (int i = 0; i < 40; i++) push_pair(i[0] ? 8'd0 : 8'd255, i[0] ? 8'd255 : 8'd0, i == 39);
    repeat (260) begin
      level = $urandom_range(255);
      push_pair(level, level, 1'b1);
    end
    run_frames(0, 0, 47);

    // back into discarding, then into stabilizing
    write_reg(CFG_DISCARD, 10'd255);
    run_frames(20, 31, 31);
    write_reg(CFG_DISCARD, 10'd40);
    write_reg(CFG_RATIO, 10'd150);
    write_reg(CFG_HOLD, 10'd1);
    run_frames(40, 0, 0);

    write_reg(CFG_RATIO, CFG_DATA_W'($urandom_range(1023)));
    write_reg(CFG_HOLD, CFG_DATA_W'($urandom_range(8)));
    run_frames(30, 31, 31);

    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[frame_diff_motion_detector_core.f]
design/fdmd_pkg.sv
design/fdmd_ifs.sv
design/fdmd_front.sv
design/fdmd_queue.sv
design/fdmd_back.sv
design/frame_diff_motion_detector_core.sv
verif/frame_diff_motion_detector_core_tb.sv
